FILE: rtl/actr_pkg.sv
// Package for the AES-128 counter-mode block crypt unit.
// Holds the S-box, GF(2^8) helpers and the shared lane type; no dependencies.
package actr_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned RegIdxW = 2;

  localparam logic [RegIdxW-1:0] RegKeyHigh = 2'd0;
  localparam logic [RegIdxW-1:0] RegKeyLow  = 2'd1;
  localparam logic [RegIdxW-1:0] RegIvHigh  = 2'd2;
  localparam logic [RegIdxW-1:0] RegIvLow   = 2'd3;

  localparam logic [7:0] PolyReduce = 8'h1b;

  // Data that travels down the round chain next to the AES state.
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
    logic [7:0]   rcon;
    logic [127:0] data;
    logic [4:0]   valid_bytes;
  } lane_t;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? PolyReduce : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  // Byte k of a 128-bit word, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int unsigned k);
    get_byte = w[127-8*k -: 8];
  endfunction

endpackage

FILE: rtl/actr_if.sv
// Valid/ready channel interfaces for the AES-128 counter-mode unit.
// Depends on nothing.
interface actr_in_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  valid_bytes;
  logic        restart;
  modport source (output valid, data_high, data_low, valid_bytes, restart, input ready);
  modport sink (input valid, data_high, data_low, valid_bytes, restart, output ready);
endinterface

interface actr_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  modport source (output valid, out_high, out_low, input ready);
  modport sink (input valid, out_high, out_low, output ready);
endinterface

interface actr_cfg_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/aes128_ctr_block_crypt_unit.sv
// Top level of the AES-128 counter-mode block crypt unit.
// Depends on actr_pkg, actr_if and actr_round_cell.
//
// Usage:
// The cfg channel writes key_high, key_low, iv_high and iv_low (index 0..3)
// and is always ready. Each in beat carries a 16-byte block, its count of
// valid bytes and a restart flag that reloads the counter from the IV before
// the block is used. Each in beat yields exactly one out beat with the data
// XOR keystream, bytes at or beyond valid_bytes set to zero.
// The counter is encrypted by a chain of ten round cells, one register each,
// plus an output register.
// The chain advances in every cycle in which the output register is empty or
// its beat is taken, so one block per cycle is sustained.
// When the receiver stalls the whole chain holds and in ready stays low for as
// long as a beat waits in the output register; no beat is lost. Reset clears
// the counter, the cfg registers and all valid flags, not the payload registers; no clearing pass is needed.
module aes128_ctr_block_crypt_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  actr_cfg_if.sink      cfg_i,
  actr_in_if.sink       in_i,
  actr_out_if.source    out_o
);
  import actr_pkg::*;

  logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic [127:0] ctr_q, ctr_d, ctr_use;
  logic         adv;
  logic         in_fire;
  logic         vld [RoundCount+1];
  lane_t        lane [RoundCount+1];
  logic         out_valid_q;
  logic [127:0] out_q, out_d;
  lane_t        fin;

  // The chain moves unless a finished beat waits in the output register.
  assign adv       = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;
  assign in_fire   = in_i.valid && adv;
  assign cfg_i.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegKeyHigh: key_high_q <= cfg_i.wdata;
        RegKeyLow:  key_low_q  <= cfg_i.wdata;
        RegIvHigh:  iv_high_q  <= cfg_i.wdata;
        RegIvLow:   iv_low_q   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Counter: optional reload, then big-endian increment per block.
  assign ctr_use = in_i.restart ? {iv_high_q, iv_low_q} : ctr_q;
  assign ctr_d   = ctr_use + 128'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
    end else if (in_fire) begin
      ctr_q <= ctr_d;
    end
  end

  // Entry of the chain with the initial AddRoundKey.
  always_comb begin
    lane[0].state       = ctr_use ^ {key_high_q, key_low_q};
    lane[0].rkey        = {key_high_q, key_low_q};
    lane[0].rcon        = 8'h01;
    lane[0].data        = {in_i.data_high, in_i.data_low};
    lane[0].valid_bytes = in_i.valid_bytes;
    vld[0]              = in_i.valid;
  end

  for (genvar g = 0; g < RoundCount; g++) begin : g_round
    actr_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .last_i  (g == RoundCount - 1),
      .valid_i (vld[g]),
      .lane_i  (lane[g]),
      .valid_o (vld[g+1]),
      .lane_o  (lane[g+1])
    );
  end

  // Keystream XOR and byte masking.
  assign fin = lane[RoundCount];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      out_d[127-8*i -: 8] = (5'(i) < fin.valid_bytes)
          ? (get_byte(fin.data, i) ^ get_byte(fin.state, i)) : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[RoundCount];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_high = out_q[127:64];
  assign out_o.out_low  = out_q[63:0];
endmodule

FILE: rtl/actr_round_cell.sv
// One AES round cell: SubBytes, ShiftRows, optional MixColumns, key step, AddRoundKey.
// Depends on actr_pkg.
module actr_round_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             last_i,
  input  logic             valid_i,
  input  actr_pkg::lane_t  lane_i,
  output logic             valid_o,
  output actr_pkg::lane_t  lane_o
);
  import actr_pkg::*;

  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [7:0]   k [16];
  logic [7:0]   tw [4];
  logic [127:0] st_new;
  logic [127:0] rk_new;
  lane_t        lane_d, lane_q;
  logic         valid_q;

  // Substitute and shift rows; byte (col c, row r) at index 4c+r.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = sbox(get_byte(lane_i.state, ((c + r) % 4) * 4 + r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      for (int r = 0; r < 4; r++) begin
        m[c*4+r] = last_i ? t[c*4+r]
                 : t[c*4+r] ^ all ^ gf_dbl(t[c*4+r] ^ t[c*4+((r+1)%4)]);
      end
    end
  end

  // Next round key from the current one.
  always_comb begin
    tw[0] = sbox(get_byte(lane_i.rkey, 13)) ^ lane_i.rcon;
    tw[1] = sbox(get_byte(lane_i.rkey, 14));
    tw[2] = sbox(get_byte(lane_i.rkey, 15));
    tw[3] = sbox(get_byte(lane_i.rkey, 12));
    for (int i = 0; i < 4; i++) begin
      k[i] = get_byte(lane_i.rkey, i) ^ tw[i];
    end
    for (int i = 4; i < 16; i++) begin
      k[i] = get_byte(lane_i.rkey, i) ^ k[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      rk_new[127-8*i -: 8] = k[i];
      st_new[127-8*i -: 8] = m[i] ^ k[i];
    end
  end

  always_comb begin
    lane_d       = lane_i;
    lane_d.state = st_new;
    lane_d.rkey  = rk_new;
    lane_d.rcon  = gf_dbl(lane_i.rcon);
  end

  // Payload register, loaded whenever the chain moves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;
endmodule
